// ----- hdl/hierarchical_bilevel_volume_decoder_core_macros.svh -----
// assertion macros for the bilevel volume decoder checker
// no dependencies
`ifndef HIERARCHICAL_BILEVEL_VOLUME_DECODER_CORE_MACROS_SVH
`define HIERARCHICAL_BILEVEL_VOLUME_DECODER_CORE_MACROS_SVH
`define HBVD_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
`define HBVD_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

// ----- hdl/hbvd_pkg.sv -----
// package for the bilevel volume decoder: sizes, axis and phase codes
// no dependencies
`timescale 1ns / 1ps
package hbvd_pkg;
    localparam int ROW_BITS = 8;
    localparam int COL_BITS = 8;
    localparam int FRAME_BITS = 4;
    localparam int STACK_DEPTH = ROW_BITS + COL_BITS + FRAME_BITS;
    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int ENT_W = 5;
    localparam logic [1:0] AX_ROW = 2'd0;
    localparam logic [1:0] AX_COL = 2'd1;
    localparam logic [1:0] AX_FRAME = 2'd2;
    localparam logic [2:0] IDX_ROWS = 3'd0;
    localparam logic [2:0] IDX_COLS = 3'd1;
    localparam logic [2:0] IDX_FRAMES = 3'd2;
    localparam logic [2:0] IDX_V1 = 3'd3;
    localparam logic [2:0] IDX_V0 = 3'd4;
    typedef enum logic [2:0] {
        PH_FLAG, PH_COLOUR, PH_AXIS1, PH_AXIS2, PH_PEEK
    } t_phase;
    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_POP, S_OUT
    } t_state;
endpackage

// ----- hdl/hbvd_ram.sv -----
// generic single-port synchronous ram, registered read
// no dependencies
`timescale 1ns / 1ps
module hbvd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- hdl/hierarchical_bilevel_volume_decoder_core.sv -----
// bilevel volume tree decoder top level
// depends on hbvd_pkg and hbvd_ram
//
// input channel i_code_bit/i_byte_end with i_valid/o_ready, one code bit per
// transaction, msb of each byte first. output channel o_valid/i_ready carries
// one box fill per transaction. configuration is a plain write port.
// a bit that pushes a level or only changes phase leaves the block in S_IDLE,
// so it is ready again on the next cycle. a bit that completes a region goes
// from its accept through S_READ (stack read) and S_POP (update) for each
// stack level visited (every popped level, the level that turns to its second
// half, and that level once more when its second half is an implicit pixel),
// through S_READ once more when the tree ends, and through S_OUT for each box
// while the receiver takes it. up to two boxes per bit; ready drops until the
// boxes are taken, so a stalled receiver stalls the input. after reset the
// block expects a colour bit at size 1x1x1 and default fill bytes; no clearing
// pass is needed since each stack level is written before it is read.
`timescale 1ns / 1ps
module hierarchical_bilevel_volume_decoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_code_bit,
    input  logic       i_byte_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_box_row,
    output logic [7:0] o_box_col,
    output logic [3:0] o_box_frame,
    output logic [3:0] o_box_rows_log2,
    output logic [3:0] o_box_cols_log2,
    output logic [2:0] o_box_frames_log2,
    output logic [7:0] o_pixel_value,
    output logic       o_tree_done,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import hbvd_pkg::*;

    logic [3:0] r_rows, r_cols;
    logic [2:0] r_frames;
    logic [7:0] r_v1, r_v0;
    t_state r_st, n_st;
    t_phase r_ph, n_ph;
    logic [LVL_W-1:0] r_lvl, n_lvl;
    logic [ROW_BITS-1:0] r_row, n_row;
    logic [COL_BITS-1:0] r_col, n_col;
    logic [FRAME_BITS-1:0] r_frm, n_frm;
    logic [3:0] r_sr, n_sr, r_sc, n_sc;
    logic [2:0] r_sf, n_sf;
    logic r_skip, n_skip;
    logic r_be, n_be;
    logic r_uni, n_uni, r_col1, n_col1;
    logic [7:0] r_orow [2], r_ocol [2];
    logic [3:0] r_ofrm [2], r_osr [2], r_osc [2];
    logic [2:0] r_osf [2];
    logic [7:0] r_oval [2];
    logic [1:0] r_n, n_n;
    logic r_oi, n_oi;
    logic r_done, n_done;
    logic       ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [ENT_W-1:0] ram_wd, ram_rd;
    logic e_emit0, e_emit1;
    logic e_c0, e_c1;
    logic pix;

    hbvd_ram #(.WIDTH(ENT_W), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wd), .o_rdata(ram_rd)
    );

    // stack entry: {axis[1:0], second, first_uniform, first_colour}
    function automatic logic [3:0] clamp4(input logic [3:0] v, input int hi);
        clamp4 = (int'(v) > hi) ? 4'(hi) : v;
    endfunction

    logic [3:0] cl_r, cl_c, cl_f;
    assign cl_r = clamp4(r_rows, ROW_BITS);
    assign cl_c = clamp4(r_cols, COL_BITS);
    assign cl_f = clamp4({1'b0, r_frames}, FRAME_BITS);

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_box_row = r_orow[r_oi];
    assign o_box_col = r_ocol[r_oi];
    assign o_box_frame = r_ofrm[r_oi];
    assign o_box_rows_log2 = r_osr[r_oi];
    assign o_box_cols_log2 = r_osc[r_oi];
    assign o_box_frames_log2 = r_osf[r_oi];
    assign o_pixel_value = r_oval[r_oi];
    assign o_tree_done = r_done && ((r_n == 2'd1) || r_oi);

    always_comb begin
        logic [1:0] ax;
        logic [3:0] sz;
        logic [2:0] dirs;
        logic cut;
        logic [1:0] cax;
        logic [ENT_W-1:0] e;
        logic [11:0] step;
        n_st = r_st; n_ph = r_ph; n_lvl = r_lvl;
        n_row = r_row; n_col = r_col; n_frm = r_frm;
        n_sr = r_sr; n_sc = r_sc; n_sf = r_sf; n_skip = r_skip;
        n_be = r_be; n_uni = r_uni; n_col1 = r_col1;
        n_n = r_n; n_oi = r_oi; n_done = r_done;
        ram_we = 1'b0; ram_addr = ADDR_W'(r_lvl - 1'b1); ram_wd = '0;
        e_emit0 = 1'b0; e_emit1 = 1'b0; e_c0 = 1'b0; e_c1 = 1'b0;
        cut = 1'b0; cax = AX_ROW; e = ram_rd; ax = AX_ROW; sz = '0; step = '0;
        pix = (r_sr == 0) && (r_sc == 0) && (r_sf == 0);
        dirs = 3'(r_sr != 0) + 3'(r_sc != 0) + 3'(r_sf != 0);
        case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    n_be = i_byte_end;
                    n_n = 2'd0; n_oi = 1'b0; n_done = 1'b0;
                    if (r_skip) begin
                        if (i_byte_end) n_skip = 1'b0;
                    end else begin
                        case (r_ph)
                            PH_FLAG: begin
                                if (pix) begin
                                    e_emit0 = 1'b1; e_c0 = i_code_bit;
                                end else if (i_code_bit) n_ph = PH_COLOUR;
                                else if (dirs >= 2) n_ph = PH_AXIS1;
                                else begin
                                    cut = 1'b1;
                                    cax = (r_sf != 0) ? AX_FRAME :
                                          (r_sc != 0) ? AX_COL : AX_ROW;
                                end
                            end
                            PH_COLOUR: begin e_emit0 = 1'b1; e_c0 = i_code_bit; end
                            PH_AXIS1: begin
                                if (dirs == 3) begin
                                    if (i_code_bit) n_ph = PH_AXIS2;
                                    else begin cut = 1'b1; cax = AX_COL; end
                                end else begin
                                    cut = 1'b1;
                                    if (r_sf == 0) cax = i_code_bit ? AX_ROW : AX_COL;
                                    else if (r_sr == 0) cax = i_code_bit ? AX_FRAME : AX_COL;
                                    else cax = i_code_bit ? AX_FRAME : AX_ROW;
                                end
                            end
                            PH_AXIS2: begin cut = 1'b1; cax = i_code_bit ? AX_FRAME : AX_ROW; end
                            PH_PEEK: begin
                                if (i_code_bit) begin
                                    e_emit0 = 1'b1;
                                    e_c0 = (r_lvl != 0) ? ~r_col1 : 1'b1;
                                end else if (dirs >= 2) n_ph = PH_AXIS1;
                                else begin
                                    cut = 1'b1;
                                    cax = (r_sf != 0) ? AX_FRAME :
                                          (r_sc != 0) ? AX_COL : AX_ROW;
                                end
                            end
                            default: n_ph = PH_FLAG;
                        endcase
                        if (cut) begin
                            n_ph = PH_FLAG;
                            sz = (cax == AX_ROW) ? r_sr : (cax == AX_COL) ? r_sc : 4'(r_sf);
                            if (sz != 0 && r_lvl < LVL_W'(STACK_DEPTH)) begin
                                ram_we = 1'b1; ram_addr = ADDR_W'(r_lvl);
                                ram_wd = {cax, 3'b000};
                                if (cax == AX_ROW) n_sr = r_sr - 1'b1;
                                else if (cax == AX_COL) n_sc = r_sc - 1'b1;
                                else n_sf = r_sf - 3'd1;
                                n_lvl = r_lvl + 1'b1;
                            end
                        end
                        if (e_emit0) begin
                            n_uni = 1'b1; n_col1 = e_c0; n_n = 2'd1;
                            n_st = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                // issue stack read of top level (addr defaults to lvl-1)
                if (r_lvl == 0) begin
                    n_done = 1'b1; n_skip = ~r_be;
                    n_lvl = '0; n_ph = PH_FLAG;
                    n_sr = cl_r; n_sc = cl_c; n_sf = 3'(cl_f);
                    n_row = '0; n_col = '0; n_frm = '0;
                    n_st = S_OUT;
                end else n_st = S_POP;
            end
            S_POP: begin
                ax = (e[4:3] > AX_FRAME) ? AX_FRAME : e[4:3];
                sz = (ax == AX_ROW) ? r_sr : (ax == AX_COL) ? r_sc : 4'(r_sf);
                step = 12'd1 << sz;
                if (!e[2]) begin
                    ram_we = 1'b1;
                    ram_wd = {e[4:3], 1'b1, r_uni, r_col1};
                    if (ax == AX_ROW) n_row = r_row + ROW_BITS'(step);
                    else if (ax == AX_COL) n_col = r_col + COL_BITS'(step);
                    else n_frm = r_frm + FRAME_BITS'(step);
                    if (pix && r_n == 2'd1) begin
                        e_emit1 = 1'b1; e_c1 = ~r_col1;
                        n_col1 = ~r_col1; n_uni = 1'b1; n_n = 2'd2;
                        n_st = S_READ;
                    end else begin
                        n_ph = r_uni ? PH_PEEK : PH_FLAG;
                        n_st = (r_n != 0) ? S_OUT : S_IDLE;
                    end
                end else begin
                    if (ax == AX_ROW) begin n_row = r_row - ROW_BITS'(step); n_sr = r_sr + 1'b1; end
                    else if (ax == AX_COL) begin n_col = r_col - COL_BITS'(step); n_sc = r_sc + 1'b1; end
                    else begin n_frm = r_frm - FRAME_BITS'(step); n_sf = r_sf + 3'd1; end
                    n_lvl = r_lvl - 1'b1;
                    n_uni = 1'b0; n_col1 = 1'b0;
                    n_st = S_READ;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    if (r_oi == 1'b0 && r_n == 2'd2) n_oi = 1'b1;
                    else n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
        // a size write restarts the tree at the new size
        if (i_cfg_we && (i_cfg_index inside {IDX_ROWS, IDX_COLS, IDX_FRAMES})) begin
            n_sr = clamp4((i_cfg_index == IDX_ROWS) ? i_cfg_data[3:0] : r_rows, ROW_BITS);
            n_sc = clamp4((i_cfg_index == IDX_COLS) ? i_cfg_data[3:0] : r_cols, COL_BITS);
            n_sf = 3'(clamp4({1'b0, (i_cfg_index == IDX_FRAMES) ?
                              i_cfg_data[2:0] : r_frames}, FRAME_BITS));
            n_row = '0; n_col = '0; n_frm = '0;
            n_lvl = '0; n_ph = PH_FLAG; n_skip = 1'b0;
        end
    end

    // box capture uses the current position, or the advanced one for an implicit second-half pixel
    logic cap_slot;
    assign cap_slot = e_emit1;

    always_ff @(posedge i_clk) begin
        if (e_emit0 || e_emit1) begin
            r_orow[cap_slot] <= 8'(e_emit1 ? n_row : r_row);
            r_ocol[cap_slot] <= 8'(e_emit1 ? n_col : r_col);
            r_ofrm[cap_slot] <= 4'(e_emit1 ? n_frm : r_frm);
            r_osr[cap_slot] <= r_sr;
            r_osc[cap_slot] <= r_sc;
            r_osf[cap_slot] <= r_sf;
            r_oval[cap_slot] <= (e_emit1 ? e_c1 : e_c0) ? r_v1 : r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= '0; r_cols <= '0; r_frames <= '0;
            r_v1 <= 8'd0; r_v0 <= 8'd255;
            r_st <= S_IDLE; r_ph <= PH_FLAG; r_lvl <= '0;
            r_row <= '0; r_col <= '0; r_frm <= '0;
            r_sr <= '0; r_sc <= '0; r_sf <= '0; r_skip <= 1'b0;
            r_be <= 1'b0; r_uni <= 1'b0; r_col1 <= 1'b0;
            r_n <= '0; r_oi <= 1'b0; r_done <= 1'b0;
        end else begin
            r_st <= n_st; r_ph <= n_ph; r_lvl <= n_lvl;
            r_row <= n_row; r_col <= n_col; r_frm <= n_frm;
            r_sr <= n_sr; r_sc <= n_sc; r_sf <= n_sf; r_skip <= n_skip;
            r_be <= n_be; r_uni <= n_uni; r_col1 <= n_col1;
            r_n <= n_n; r_oi <= n_oi; r_done <= n_done;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    IDX_ROWS: r_rows <= i_cfg_data[3:0];
                    IDX_COLS: r_cols <= i_cfg_data[3:0];
                    IDX_FRAMES: r_frames <= i_cfg_data[2:0];
                    IDX_V1: r_v1 <= i_cfg_data;
                    IDX_V0: r_v0 <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

// ----- hdl/hbvd_checker.sv -----
// port-level checker for the bilevel volume decoder, with bind
// depends on hierarchical_bilevel_volume_decoder_core_macros.svh
`timescale 1ns / 1ps
`include "hierarchical_bilevel_volume_decoder_core_macros.svh"
module hbvd_port_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_pixel_value,
    input logic [3:0] o_box_rows_log2
);
    `HBVD_ASSERT_IMP(a_excl, i_clk, i_rst_n, o_valid, !o_ready)
    `HBVD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_pixel_value))
    `HBVD_ASSERT_IMP(a_size, i_clk, i_rst_n, o_valid, o_box_rows_log2 <= 4'd8)
    `HBVD_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_valid && o_ready && !o_valid, !o_valid)
endmodule

bind hierarchical_bilevel_volume_decoder_core hbvd_port_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_pixel_value(o_pixel_value),
    .o_box_rows_log2(o_box_rows_log2)
);

// ----- tb/sv/hbvd_checker.sv -----
// checker for the bilevel volume decoder: predicts box fills from the code bits and compares them
// depends on hbvd_pkg
`timescale 1ns / 1ps
module hbvd_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_ready_in,
    input  logic       i_code_bit,
    input  logic       i_byte_end,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_box_row,
    input  logic [7:0] i_box_col,
    input  logic [3:0] i_box_frame,
    input  logic [3:0] i_box_rows_log2,
    input  logic [3:0] i_box_cols_log2,
    input  logic [2:0] i_box_frames_log2,
    input  logic [7:0] i_pixel_value,
    input  logic       i_tree_done,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output int         o_errors,
    output int         o_pending,
    output int         o_boxes
);
    import hbvd_pkg::*;

    typedef struct packed {
        logic [7:0] row;
        logic [7:0] col;
        logic [3:0] frame;
        logic [3:0] rows_log2;
        logic [3:0] cols_log2;
        logic [2:0] frames_log2;
        logic [7:0] value;
        logic       done;
    } t_box;

    t_box box_fifo[$];
    t_box step_boxes[$];

    logic [3:0] reg_rows, reg_cols;
    logic [2:0] reg_frames;
    logic [7:0] reg_v1, reg_v0;

    logic [1:0] axis_stk[STACK_DEPTH];
    bit         second_stk[STACK_DEPTH];
    bit         uni_stk[STACK_DEPTH];
    bit         colour_stk[STACK_DEPTH];
    int unsigned level;
    int unsigned pos[3];
    int unsigned sz[3];
    t_phase     phase;
    bit         skipping;

    function automatic int unsigned clamp(int unsigned v, int unsigned hi);
        return v > hi ? hi : v;
    endfunction

    function automatic int unsigned pos_mask(int a);
        if (a == AX_ROW) return (1 << ROW_BITS) - 1;
        if (a == AX_COL) return (1 << COL_BITS) - 1;
        return (1 << FRAME_BITS) - 1;
    endfunction

    task automatic load_tree();
        sz[AX_ROW] = clamp(reg_rows, ROW_BITS);
        sz[AX_COL] = clamp(reg_cols, COL_BITS);
        sz[AX_FRAME] = clamp(reg_frames, FRAME_BITS);
        pos[0] = 0;
        pos[1] = 0;
        pos[2] = 0;
        level = 0;
        phase = PH_FLAG;
    endtask

    function automatic bit single_pixel();
        return sz[0] == 0 && sz[1] == 0 && sz[2] == 0;
    endfunction

    task automatic emit_box(bit colour);
        t_box b;
        if (step_boxes.size() >= 2) return;
        b.row = pos[AX_ROW][7:0];
        b.col = pos[AX_COL][7:0];
        b.frame = pos[AX_FRAME][3:0];
        b.rows_log2 = sz[AX_ROW][3:0];
        b.cols_log2 = sz[AX_COL][3:0];
        b.frames_log2 = sz[AX_FRAME][2:0];
        b.value = colour ? reg_v1 : reg_v0;
        b.done = 1'b0;
        step_boxes.push_back(b);
    endtask

    task automatic cut(logic [1:0] a);
        phase = PH_FLAG;
        if (sz[a] == 0 || level >= STACK_DEPTH) return;
        axis_stk[level] = a;
        second_stk[level] = 0;
        uni_stk[level] = 0;
        colour_stk[level] = 0;
        sz[a]--;
        level++;
    endtask

    task automatic start_split();
        int dirs;
        dirs = (sz[0] > 0) + (sz[1] > 0) + (sz[2] > 0);
        if (dirs >= 2) phase = PH_AXIS1;
        else if (sz[AX_FRAME] > 0) cut(AX_FRAME);
        else if (sz[AX_COL] > 0) cut(AX_COL);
        else cut(AX_ROW);
    endtask

    task automatic close_region(bit uniform, bit colour, bit be);
        int unsigned lv;
        logic [1:0] a;
        forever begin
            if (level == 0) begin
                if (step_boxes.size() > 0) step_boxes[step_boxes.size() - 1].done = 1'b1;
                load_tree();
                skipping = !be;
                return;
            end
            lv = level - 1;
            a = axis_stk[lv];
            if (!second_stk[lv]) begin
                second_stk[lv] = 1;
                uni_stk[lv] = uniform;
                colour_stk[lv] = colour;
                pos[a] = (pos[a] + (1 << sz[a])) & pos_mask(a);
                if (single_pixel()) begin
                    colour = !colour;
                    emit_box(colour);
                    uniform = 1;
                    continue;
                end
                phase = uniform ? PH_PEEK : PH_FLAG;
                return;
            end
            pos[a] = (pos[a] - (1 << sz[a])) & pos_mask(a);
            sz[a]++;
            level = lv;
            uniform = 0;
            colour = 0;
        end
    endtask

    task automatic decode_bit(bit cb, bit be);
        bit colour;
        if (skipping) begin
            if (be) skipping = 0;
            return;
        end
        case (phase)
            PH_FLAG: begin
                if (single_pixel()) begin
                    emit_box(cb);
                    close_region(1, cb, be);
                end else if (cb) phase = PH_COLOUR;
                else start_split();
            end
            PH_COLOUR: begin
                emit_box(cb);
                close_region(1, cb, be);
            end
            PH_AXIS1: begin
                if (sz[0] > 0 && sz[1] > 0 && sz[2] > 0) begin
                    if (cb) phase = PH_AXIS2;
                    else cut(AX_COL);
                end else if (sz[AX_FRAME] == 0) cut(cb ? AX_ROW : AX_COL);
                else if (sz[AX_ROW] == 0) cut(cb ? AX_FRAME : AX_COL);
                else cut(cb ? AX_FRAME : AX_ROW);
            end
            PH_AXIS2: cut(cb ? AX_FRAME : AX_ROW);
            PH_PEEK: begin
                if (cb) begin
                    colour = (level > 0) ? !colour_stk[level - 1] : 1'b1;
                    emit_box(colour);
                    close_region(1, colour, be);
                end else start_split();
            end
            default: phase = PH_FLAG;
        endcase
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_box e;
        if (!i_rst_n) begin
            box_fifo.delete();
            reg_rows = 0;
            reg_cols = 0;
            reg_frames = 0;
            reg_v1 = 8'd0;
            reg_v0 = 8'd255;
            load_tree();
            skipping = 0;
            o_errors = 0;
            o_boxes = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_boxes++;
                if (box_fifo.size() == 0) begin
                    report("unexpected transaction, row", i_box_row, 0);
                end else begin
                    e = box_fifo.pop_front();
                    if (i_box_row !== e.row) report("box_row", i_box_row, e.row);
                    if (i_box_col !== e.col) report("box_col", i_box_col, e.col);
                    if (i_box_frame !== e.frame) report("box_frame", i_box_frame, e.frame);
                    if (i_box_rows_log2 !== e.rows_log2)
                        report("box_rows_log2", i_box_rows_log2, e.rows_log2);
                    if (i_box_cols_log2 !== e.cols_log2)
                        report("box_cols_log2", i_box_cols_log2, e.cols_log2);
                    if (i_box_frames_log2 !== e.frames_log2)
                        report("box_frames_log2", i_box_frames_log2, e.frames_log2);
                    if (i_pixel_value !== e.value) report("pixel_value", i_pixel_value, e.value);
                    if (i_tree_done !== e.done) report("tree_done", i_tree_done, e.done);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    IDX_ROWS: reg_rows = i_cfg_data[3:0];
                    IDX_COLS: reg_cols = i_cfg_data[3:0];
                    IDX_FRAMES: reg_frames = i_cfg_data[2:0];
                    IDX_V1: reg_v1 = i_cfg_data;
                    IDX_V0: reg_v0 = i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_index == IDX_ROWS || i_cfg_index == IDX_COLS
                        || i_cfg_index == IDX_FRAMES) begin
                    load_tree();
                    skipping = 0;
                end
            end
            if (i_valid && i_ready_in) begin
                step_boxes.delete();
                decode_bit(i_code_bit, i_byte_end);
                foreach (step_boxes[k]) box_fifo.push_back(step_boxes[k]);
            end
        end
        o_pending <= box_fifo.size();
    end
endmodule

// ----- tb/sv/testbench.sv -----
// top of the bilevel volume decoder testbench: clock, reset, code bit stimulus, verdict
// depends on hbvd_pkg, hbvd_checker and hierarchical_bilevel_volume_decoder_core
`timescale 1ns / 1ps
module testbench;
    import hbvd_pkg::*;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_valid = 0;
    logic       o_ready;
    logic       i_code_bit = 0;
    logic       i_byte_end = 0;
    logic       o_valid;
    logic       i_ready = 0;
    logic [7:0] o_box_row, o_box_col, o_pixel_value;
    logic [3:0] o_box_frame, o_box_rows_log2, o_box_cols_log2;
    logic [2:0] o_box_frames_log2;
    logic       o_tree_done;
    logic       i_cfg_we = 0;
    logic [2:0] i_cfg_index = IDX_ROWS;
    logic [7:0] i_cfg_data = 0;

    int errors, pending, boxes;
    int bits_sent = 0;
    int settings = 0;
    bit no_gaps = 0;
    bit stalled_once = 0;

    hierarchical_bilevel_volume_decoder_core u_dut (.*);

    hbvd_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_code_bit(i_code_bit), .i_byte_end(i_byte_end), .i_out_valid(o_valid),
        .i_out_ready(i_ready), .i_box_row(o_box_row), .i_box_col(o_box_col),
        .i_box_frame(o_box_frame), .i_box_rows_log2(o_box_rows_log2),
        .i_box_cols_log2(o_box_cols_log2), .i_box_frames_log2(o_box_frames_log2),
        .i_pixel_value(o_pixel_value), .i_tree_done(o_tree_done), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data), .o_errors(errors),
        .o_pending(pending), .o_boxes(boxes)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_bit(bit cb, bit be);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_code_bit <= cb;
        i_byte_end <= be;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bits_sent++;
    endtask

    task automatic send_random(int n);
        int k;
        for (k = 0; k < n; k++)
            send_bit(1'($urandom_range(0, 1)),
                     ($urandom_range(0, 19) == 0) ? 1'($urandom_range(0, 1))
                                                  : 1'(k % 8 == 7));
    endtask

    task automatic settle();
        if (i_valid) i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_block(int r, int c, int f, int v1, int v0);
        settle();
        i_cfg_we <= 1;
        i_cfg_index <= IDX_ROWS; i_cfg_data <= 8'(r); @(posedge i_clk);
        i_cfg_index <= IDX_COLS; i_cfg_data <= 8'(c); @(posedge i_clk);
        i_cfg_index <= IDX_FRAMES; i_cfg_data <= 8'(f); @(posedge i_clk);
        i_cfg_index <= IDX_V1; i_cfg_data <= 8'(v1); @(posedge i_clk);
        i_cfg_index <= IDX_V0; i_cfg_data <= 8'(v0); @(posedge i_clk);
        i_cfg_we <= 0;
        settings++;
    endtask

    // receiver: random stalls plus one long hold-off while the sender keeps going
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                i_ready <= 0;
            end else if (!stalled_once && bits_sent > 600) begin
                stalled_once = 1;
                hold = 400;
                i_ready <= 0;
            end else if (no_gaps || $urandom_range(0, 99) < 65) begin
                i_ready <= 1;
            end else begin
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 3);
                i_ready <= 0;
            end
        end
    end

    initial begin
        #8_000_000;
        $display("hierarchical_bilevel_volume_decoder_core test failed");
        $finish;
    end

    initial begin
        int p;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // single pixel block: each decoded bit is a box, padding skip when byte not ended
        send_bit(1, 1);
        send_bit(0, 1);
        send_bit(1, 0);
        send_bit(0, 0);
        send_bit(1, 1);
        send_bit(0, 1);
        // 2x2x2 block: three-axis cut codes, implicit partner, peek fill and peek split
        set_block(1, 1, 1, 8'h00, 8'hFF);
        send_bit(0, 0); send_bit(0, 0); send_bit(0, 0); send_bit(0, 0);
        send_bit(1, 0); send_bit(1, 0); send_bit(0, 0); send_bit(1, 1);
        send_bit(0, 0); send_bit(1, 0); send_bit(1, 0); send_bit(1, 0);
        send_bit(1, 0); send_bit(0, 0); send_bit(1, 0); send_bit(0, 1);
        send_bit(0, 0); send_bit(1, 0); send_bit(0, 0);
        for (p = 0; p < 9; p++) begin
            no_gaps = (p % 4 == 3);
            case (p)
                0: set_block(8, 8, 4, 8'hFF, 8'h00);
                1: set_block(15, 15, 7, $urandom_range(0, 255), $urandom_range(0, 255));
                2: set_block(0, 3, 0, 8'hA5, 8'h5A);
                3: set_block(2, 0, 2, $urandom_range(0, 255), $urandom_range(0, 255));
                default: set_block($urandom_range(0, 3), $urandom_range(0, 3),
                                   $urandom_range(0, 2), $urandom_range(0, 255),
                                   $urandom_range(0, 255));
            endcase
            send_random(158);
        end
        settle();
        $display("sent %0d code bits over %0d block settings, %0d box fills checked",
                 bits_sent, settings, boxes);
        if (errors == 0)
            $display("hierarchical_bilevel_volume_decoder_core test passed");
        else
            $display("hierarchical_bilevel_volume_decoder_core test failed");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/hbvd_pkg.sv
hdl/hbvd_ram.sv
hdl/hierarchical_bilevel_volume_decoder_core.sv
hdl/hbvd_checker.sv
tb/sv/hbvd_checker.sv
tb/sv/testbench.sv
